// ===== rtl/core/cst_pkg.sv =====
// ----------------------------------------------------------------------------
// cst_pkg - shared types and constants of the character stream tokenizer
// Token kind codes, keyword table, position width and the result records
// passed between the scanner, the result queue and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package cst_pkg;

  // Position counter saturates at this value
  localparam longint unsigned POS_LIMIT = 64'd65535;
  localparam int POS_W = $clog2(POS_LIMIT + 64'd1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(POS_LIMIT);

  // Identifier bytes kept for keyword matching
  localparam int KEYWORD_BYTES = 8;
  localparam int WORD_W = 8 * KEYWORD_BYTES;
  localparam int LEN_W = $clog2(KEYWORD_BYTES + 2);
  localparam logic [LEN_W-1:0] WORD_FULL = LEN_W'(KEYWORD_BYTES);
  localparam logic [LEN_W-1:0] WORD_OVER = LEN_W'(KEYWORD_BYTES + 1);

  // Token kinds
  localparam logic [5:0] KIND_LBRACE = 6'd0;
  localparam logic [5:0] KIND_RBRACE = 6'd1;
  localparam logic [5:0] KIND_LBRACK = 6'd2;
  localparam logic [5:0] KIND_RBRACK = 6'd3;
  localparam logic [5:0] KIND_LPAREN = 6'd4;
  localparam logic [5:0] KIND_RPAREN = 6'd5;
  localparam logic [5:0] KIND_SEMI   = 6'd6;
  localparam logic [5:0] KIND_COMMA  = 6'd7;
  localparam logic [5:0] KIND_DOT    = 6'd8;
  localparam logic [5:0] KIND_PLUS   = 6'd9;
  localparam logic [5:0] KIND_MINUS  = 6'd10;
  localparam logic [5:0] KIND_POW    = 6'd11;
  localparam logic [5:0] KIND_STAR   = 6'd12;
  localparam logic [5:0] KIND_SLASH  = 6'd13;
  localparam logic [5:0] KIND_PCT    = 6'd14;
  localparam logic [5:0] KIND_BAR    = 6'd15;
  localparam logic [5:0] KIND_AMP    = 6'd16;
  localparam logic [5:0] KIND_EQEQ   = 6'd17;
  localparam logic [5:0] KIND_ASSIGN = 6'd18;
  localparam logic [5:0] KIND_NEQ    = 6'd19;
  localparam logic [5:0] KIND_NOT    = 6'd20;
  localparam logic [5:0] KIND_GE     = 6'd21;
  localparam logic [5:0] KIND_GT     = 6'd22;
  localparam logic [5:0] KIND_LE     = 6'd23;
  localparam logic [5:0] KIND_LT     = 6'd24;
  localparam logic [5:0] KIND_INT    = 6'd25;
  localparam logic [5:0] KIND_FLOAT  = 6'd26;
  localparam logic [5:0] KIND_IDENT  = 6'd27;
  localparam logic [5:0] KIND_STRING = 6'd28;
  localparam logic [5:0] KIND_KEY0   = 6'd29;
  localparam logic [5:0] KIND_EOF    = 6'd44;
  localparam logic [5:0] KIND_ERR    = 6'd45;

  // Keyword table, packed first byte highest, right aligned
  localparam int NUM_KEYWORDS = 15;
  localparam logic [WORD_W-1:0] KW_TEXT [NUM_KEYWORDS] = '{
    WORD_W'("mod"), WORD_W'("print"), WORD_W'("tick"), WORD_W'("hold"),
    WORD_W'("let"), WORD_W'("con"), WORD_W'("if"), WORD_W'("elif"),
    WORD_W'("else"), WORD_W'("for"), WORD_W'("in"), WORD_W'("while"),
    WORD_W'("break"), WORD_W'("continue"), WORD_W'("return")
  };
  localparam logic [LEN_W-1:0] KW_LEN [NUM_KEYWORDS] = '{
    LEN_W'(3), LEN_W'(5), LEN_W'(4), LEN_W'(4), LEN_W'(3), LEN_W'(3),
    LEN_W'(2), LEN_W'(4), LEN_W'(4), LEN_W'(3), LEN_W'(2), LEN_W'(5),
    LEN_W'(5), LEN_W'(8), LEN_W'(6)
  };

  // One result item
  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] start_pos;
    logic [15:0] end_pos;
    logic        last;
  } res_t;

  // Results caused by one accepted item, in order a then b
  typedef struct packed {
    logic a_valid;
    res_t a;
    logic b_valid;
    res_t b;
  } push_t;

endpackage

`default_nettype wire

// ===== rtl/core/character_stream_tokenizer.sv =====
// ----------------------------------------------------------------------------
// character_stream_tokenizer - streaming lexical tokenizer
// Takes source text one byte per item, skips whitespace and comments and
// emits token kind with first and last character positions.
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake               payload
//   in_       input       in_valid / in_ready     text_byte, end_marker
//   out_      output      out_valid / out_ready   token_kind, start_pos,
//                                                 end_pos, run_last
//
// One item is taken per cycle while in_ready is high; the scan state
// updates in that same cycle and its zero, one or two results enter a
// four-entry result queue, reaching out_ once the results ahead are taken.
// in_ready is high while the queue holds at most two results; out_ drains
// one result per cycle, so a run of two-result items or out_ stalls fill
// the queue and hold in_ready low until it drops back to two.
// Synchronous reset clears the scan state and empties the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module character_stream_tokenizer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_text_byte,
  input  wire logic        in_end_marker,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [5:0]       out_token_kind,
  output logic [15:0]      out_start_pos,
  output logic [15:0]      out_end_pos,
  output logic             out_run_last
);
  import cst_pkg::*;

  push_t push;
  res_t  res;
  logic  room;
  logic  step;

  // Accept an item only when a pair of results fits
  assign in_ready = room;
  assign step     = in_valid && room;

  cst_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .text_byte  (in_text_byte),
    .end_marker (in_end_marker),
    .push       (push)
  );

  cst_res_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  assign out_token_kind = res.kind;
  assign out_start_pos  = res.start_pos;
  assign out_end_pos    = res.end_pos;
  assign out_run_last   = res.last;

endmodule

`default_nettype wire

// ===== rtl/core/cst_keyword.sv =====
// ----------------------------------------------------------------------------
// cst_keyword - keyword matcher
// Compares the collected identifier bytes against all keywords in parallel
// and returns the keyword kind, or the identifier kind when none matches.
// ----------------------------------------------------------------------------
`default_nettype none

module cst_keyword (
  input  wire logic [cst_pkg::WORD_W-1:0] word_bytes,
  input  wire logic [cst_pkg::LEN_W-1:0]  word_len,
  output logic [5:0]                      kind
);
  import cst_pkg::*;

  // Compare every table entry; at most one can match
  always_comb begin
    kind = KIND_IDENT;
    for (int i = 0; i < NUM_KEYWORDS; i++) begin
      if (word_len == KW_LEN[i] && word_bytes == KW_TEXT[i]) begin
        kind = KIND_KEY0 + 6'(i);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/cst_scan.sv =====
// ----------------------------------------------------------------------------
// cst_scan - scan state machine
// Holds scan mode, position, token start and identifier bytes, and turns
// each accepted item combinationally into zero, one or two result items.
// ----------------------------------------------------------------------------
`default_nettype none

module cst_scan (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                step,
  input  wire logic [7:0]          text_byte,
  input  wire logic                end_marker,
  output cst_pkg::push_t           push
);
  import cst_pkg::*;

  typedef enum logic [10:0] {
    M_IDLE    = 11'b000_0000_0001,
    M_COMMENT = 11'b000_0000_0010,
    M_ERROR   = 11'b000_0000_0100,
    M_INT     = 11'b000_0000_1000,
    M_FLOAT   = 11'b000_0001_0000,
    M_IDENT   = 11'b000_0010_0000,
    M_STRING  = 11'b000_0100_0000,
    M_PSTAR   = 11'b000_1000_0000,
    M_PEQ     = 11'b001_0000_0000,
    M_PBANG   = 11'b010_0000_0000,
    M_PLT     = 11'b100_0000_0000
  } mode_t;

  // Greater-than shares the less-than pending mode; this flag tells them apart
  typedef enum logic [0:0] {
    GT_NONE = 1'b0,
    GT_PEND = 1'b1
  } gt_t;

  typedef struct packed {
    mode_t      mode;
    gt_t        gt;
    logic       emit;
    logic [5:0] kind;
    logic       set_begin;
    logic       word_start;
  } idle_t;

  typedef struct packed {
    logic [7:0] second;
    logic [5:0] dbl;
    logic [5:0] sgl;
  } pend_t;

  mode_t                 mode_r, mode_nxt;
  gt_t                   gt_r, gt_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic [POS_W-1:0]      tb_r, tb_nxt;
  logic [WORD_W-1:0]     wbytes_r, wbytes_nxt;
  logic [LEN_W-1:0]      wlen_r, wlen_nxt;
  logic [POS_W-1:0]      prev_end;
  logic [5:0]            word_kind;
  idle_t                 idle_res;
  pend_t                 pend;
  logic                  use_idle;

  function automatic logic is_space(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_word(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic res_t mk_res(logic [5:0] k, logic [POS_W-1:0] s,
                                  logic [POS_W-1:0] e);
    res_t r;
    r.kind      = k;
    r.start_pos = 16'(s);
    r.end_pos   = 16'(e);
    r.last      = 1'b0;
    return r;
  endfunction

  // Decide what a byte does when no token is open
  function automatic idle_t idle_scan(logic [7:0] c);
    idle_t r;
    r.mode       = M_IDLE;
    r.gt         = GT_NONE;
    r.emit       = 1'b0;
    r.kind       = KIND_ERR;
    r.set_begin  = 1'b0;
    r.word_start = 1'b0;
    if (is_space(c)) begin
      r.mode = M_IDLE;
    end else if (c == "#") begin
      r.mode = M_COMMENT;
    end else begin
      unique case (c)
        "{": begin r.emit = 1'b1; r.kind = KIND_LBRACE; end
        "}": begin r.emit = 1'b1; r.kind = KIND_RBRACE; end
        "[": begin r.emit = 1'b1; r.kind = KIND_LBRACK; end
        "]": begin r.emit = 1'b1; r.kind = KIND_RBRACK; end
        "(": begin r.emit = 1'b1; r.kind = KIND_LPAREN; end
        ")": begin r.emit = 1'b1; r.kind = KIND_RPAREN; end
        ";": begin r.emit = 1'b1; r.kind = KIND_SEMI; end
        ",": begin r.emit = 1'b1; r.kind = KIND_COMMA; end
        ".": begin r.emit = 1'b1; r.kind = KIND_DOT; end
        "+": begin r.emit = 1'b1; r.kind = KIND_PLUS; end
        "-": begin r.emit = 1'b1; r.kind = KIND_MINUS; end
        "/": begin r.emit = 1'b1; r.kind = KIND_SLASH; end
        "%": begin r.emit = 1'b1; r.kind = KIND_PCT; end
        "|": begin r.emit = 1'b1; r.kind = KIND_BAR; end
        "&": begin r.emit = 1'b1; r.kind = KIND_AMP; end
        "*": begin r.set_begin = 1'b1; r.mode = M_PSTAR; end
        "=": begin r.set_begin = 1'b1; r.mode = M_PEQ; end
        "!": begin r.set_begin = 1'b1; r.mode = M_PBANG; end
        ">": begin r.set_begin = 1'b1; r.mode = M_PLT; r.gt = GT_PEND; end
        "<": begin r.set_begin = 1'b1; r.mode = M_PLT; end
        "\"": begin r.set_begin = 1'b1; r.mode = M_STRING; end
        default: begin
          r.set_begin = 1'b1;
          if (is_digit(c)) begin
            r.mode = M_INT;
          end else if (is_word(c)) begin
            r.mode       = M_IDENT;
            r.word_start = 1'b1;
          end else begin
            r.emit = 1'b1;
            r.kind = KIND_ERR;
            r.mode = M_ERROR;
          end
        end
      endcase
    end
    return r;
  endfunction

  cst_keyword u_keyword (
    .word_bytes (wbytes_r),
    .word_len   (wlen_r),
    .kind       (word_kind)
  );

  // Second character and kinds of the pending operator
  always_comb begin
    pend = '{second: "=", dbl: KIND_EQEQ, sgl: KIND_ASSIGN};
    unique case (mode_r)
      M_PSTAR: pend = '{second: "*", dbl: KIND_POW, sgl: KIND_STAR};
      M_PBANG: pend = '{second: "=", dbl: KIND_NEQ, sgl: KIND_NOT};
      M_PLT: begin
        if (gt_r == GT_PEND) begin
          pend = '{second: "=", dbl: KIND_GE, sgl: KIND_GT};
        end else begin
          pend = '{second: "=", dbl: KIND_LE, sgl: KIND_LT};
        end
      end
      default: pend = '{second: "=", dbl: KIND_EQEQ, sgl: KIND_ASSIGN};
    endcase
  end

  assign prev_end = (pos_r > tb_r) ? pos_r - 1'b1 : tb_r;

  // Advance the scan for one item
  always_comb begin
    mode_nxt   = mode_r;
    gt_nxt     = gt_r;
    pos_nxt    = pos_r;
    tb_nxt     = tb_r;
    wbytes_nxt = wbytes_r;
    wlen_nxt   = wlen_r;
    push       = '0;
    use_idle   = 1'b0;
    idle_res   = idle_scan(text_byte);
    if (step && end_marker) begin
      // Flush the open token, then mark end of text and start over
      unique case (mode_r)
        M_PSTAR, M_PEQ, M_PBANG, M_PLT: begin
          push.a_valid = 1'b1;
          push.a       = mk_res(pend.sgl, tb_r, tb_r);
        end
        M_INT: begin
          push.a_valid = 1'b1;
          push.a       = mk_res(KIND_INT, tb_r, prev_end);
        end
        M_FLOAT: begin
          push.a_valid = 1'b1;
          push.a       = mk_res(KIND_FLOAT, tb_r, prev_end);
        end
        M_IDENT: begin
          push.a_valid = 1'b1;
          push.a       = mk_res(word_kind, tb_r, prev_end);
        end
        M_STRING: begin
          push.a_valid = 1'b1;
          push.a       = mk_res(KIND_ERR, tb_r, tb_r);
        end
        default: push.a_valid = 1'b0;
      endcase
      push.b_valid = 1'b1;
      push.b       = mk_res(KIND_EOF, pos_r, pos_r);
      mode_nxt     = M_IDLE;
      gt_nxt       = GT_NONE;
      pos_nxt      = '0;
      tb_nxt       = '0;
      wbytes_nxt   = '0;
      wlen_nxt     = '0;
    end else if (step) begin
      unique case (mode_r)
        M_PSTAR, M_PEQ, M_PBANG, M_PLT: begin
          mode_nxt = M_IDLE;
          if (text_byte == pend.second) begin
            push.a_valid = 1'b1;
            push.a       = mk_res(pend.dbl, tb_r, pos_r);
          end else begin
            push.a_valid = 1'b1;
            push.a       = mk_res(pend.sgl, tb_r, tb_r);
            use_idle     = 1'b1;
          end
        end
        M_COMMENT: begin
          if (text_byte == 8'h0a) begin
            mode_nxt = M_IDLE;
          end
        end
        M_ERROR: mode_nxt = M_ERROR;
        M_INT, M_FLOAT: begin
          if (is_digit(text_byte)) begin
            mode_nxt = mode_r;
          end else if (mode_r == M_INT && text_byte == ".") begin
            mode_nxt = M_FLOAT;
          end else begin
            push.a_valid = 1'b1;
            push.a = mk_res((mode_r == M_INT) ? KIND_INT : KIND_FLOAT, tb_r, prev_end);
            use_idle = 1'b1;
          end
        end
        M_IDENT: begin
          if (is_word(text_byte)) begin
            if (wlen_r < WORD_FULL) begin
              wbytes_nxt = {wbytes_r[WORD_W-9:0], text_byte};
              wlen_nxt   = wlen_r + 1'b1;
            end else begin
              wlen_nxt = WORD_OVER;
            end
          end else begin
            push.a_valid = 1'b1;
            push.a       = mk_res(word_kind, tb_r, prev_end);
            use_idle     = 1'b1;
          end
        end
        M_STRING: begin
          if (text_byte == "\"") begin
            push.a_valid = 1'b1;
            push.a       = mk_res(KIND_STRING, tb_r, pos_r);
            mode_nxt     = M_IDLE;
          end else if (text_byte == 8'h0a) begin
            push.a_valid = 1'b1;
            push.a       = mk_res(KIND_ERR, tb_r, tb_r);
            mode_nxt     = M_ERROR;
          end
        end
        default: use_idle = 1'b1;
      endcase
      // Start whatever the byte begins when no token is open
      if (use_idle) begin
        mode_nxt = idle_res.mode;
        gt_nxt   = idle_res.gt;
        if (idle_res.emit) begin
          push.b_valid = 1'b1;
          push.b       = mk_res(idle_res.kind, pos_r, pos_r);
        end
        if (idle_res.set_begin) begin
          tb_nxt = pos_r;
        end
        if (idle_res.word_start) begin
          wbytes_nxt = WORD_W'(text_byte);
          wlen_nxt   = LEN_W'(1);
        end
      end
      if (pos_r < POS_MAX) begin
        pos_nxt = pos_r + 1'b1;
      end
    end
    // Mark the last result of this item
    push.a.last = !push.b_valid;
    push.b.last = 1'b1;
  end

  // Hold scan state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      gt_r     <= GT_NONE;
      pos_r    <= '0;
      tb_r     <= '0;
      wbytes_r <= '0;
      wlen_r   <= '0;
    end else begin
      mode_r   <= mode_nxt;
      gt_r     <= gt_nxt;
      pos_r    <= pos_nxt;
      tb_r     <= tb_nxt;
      wbytes_r <= wbytes_nxt;
      wlen_r   <= wlen_nxt;
    end
  end

  a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    step && end_marker |=> mode_r == M_IDLE && pos_r == '0 && wlen_r == '0)
    else $error("scan state not cleared after end of text");

  a_end_emits_eof: assert property (@(posedge clk) disable iff (!rst_n)
    step && end_marker |-> push.b_valid && push.b.kind == KIND_EOF)
    else $error("end of text item without end token");

  a_begin_order: assert property (@(posedge clk) disable iff (!rst_n)
    tb_r <= pos_r && pos_r <= POS_MAX)
    else $error("token start beyond position or position beyond limit");

endmodule

`default_nettype wire

// ===== rtl/core/cst_res_queue.sv =====
// ----------------------------------------------------------------------------
// cst_res_queue - result queue
// Four-entry queue that takes up to two result items per cycle and
// presents one at a time on the output handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module cst_res_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire cst_pkg::push_t push,
  output logic                room,
  output logic                out_valid,
  input  wire logic           out_ready,
  output cst_pkg::res_t       out_res
);
  import cst_pkg::*;

  res_t       mem_r [4];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [1:0] n_push;
  logic       pop;
  res_t       w0;

  // Compact the pair and update occupancy
  always_comb begin
    n_push     = {1'b0, push.a_valid} + {1'b0, push.b_valid};
    w0         = push.a_valid ? push.a : push.b;
    pop        = (cnt_r != 3'd0) && out_ready;
    cnt_nxt    = cnt_r + {1'b0, n_push} - {2'b00, pop};
    wr_ptr_nxt = wr_ptr_r + n_push;
    rd_ptr_nxt = rd_ptr_r + {1'b0, pop};
  end

  assign room      = (cnt_r <= 3'd2);
  assign out_valid = (cnt_r != 3'd0);
  assign out_res   = mem_r[rd_ptr_r];

  // Advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store incoming items
  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem_r[wr_ptr_r] <= w0;
    end
    if (n_push == 2'd2) begin
      mem_r[wr_ptr_r + 2'd1] <= push.b;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'd4)
    else $error("result queue overflow");

  a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    !room |-> n_push == 2'd0)
    else $error("result pushed without room for a pair");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_res))
    else $error("waiting result item changed before it was taken");

endmodule

`default_nettype wire

// ===== tb/token_check_pkg.sv =====
// ----------------------------------------------------------------------------
// token_check_pkg - token predictor and result scoreboard for the tokenizer
// Tracks the scan state per accepted item, predicts the token results each
// item causes and checks every result item against the oldest prediction.
// ----------------------------------------------------------------------------
package token_check_pkg;
  import cst_pkg::*;

  typedef enum logic [3:0] {
    SCAN_IDLE, SCAN_COMMENT, SCAN_ERROR, SCAN_INT, SCAN_FLOAT, SCAN_IDENT,
    SCAN_STRING, SCAN_STAR, SCAN_EQ, SCAN_BANG, SCAN_GT, SCAN_LT
  } scan_mode_e;

  // Keyword spellings in token kind order
  function automatic string keyword_name(int unsigned idx);
    case (idx)
      0: return "mod";
      1: return "print";
      2: return "tick";
      3: return "hold";
      4: return "let";
      5: return "con";
      6: return "if";
      7: return "elif";
      8: return "else";
      9: return "for";
      10: return "in";
      11: return "while";
      12: return "break";
      13: return "continue";
      default: return "return";
    endcase
  endfunction

  class token_scoreboard;
    scan_mode_e  mode;
    logic [15:0] pos;
    logic [15:0] tok_begin;
    logic [63:0] word;
    int unsigned word_len;
    res_t        item_res[$];
    res_t        token_q[$];
    int unsigned errors;

    function new();
      errors = 0;
      clear_scan();
    endfunction

    function void clear_scan();
      mode = SCAN_IDLE;
      pos = '0;
      tok_begin = '0;
      word = '0;
      word_len = 0;
    endfunction

    // Hold at most two results per item
    function void emit(logic [5:0] kind, logic [15:0] s, logic [15:0] e);
      res_t r;
      r.kind = kind;
      r.start_pos = s;
      r.end_pos = e;
      r.last = 1'b0;
      if (item_res.size() < 2) item_res.insert(item_res.size(), r);
    endfunction

    function bit is_space(logic [7:0] c);
      return c == " " || (c >= "\t" && c <= "\r");
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit is_word(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    // Last character of a token closed by the current byte
    function logic [15:0] prev_end();
      return (pos > tok_begin) ? pos - 16'd1 : tok_begin;
    endfunction

    function logic [5:0] word_kind();
      string       name;
      logic [63:0] packed_name;
      if (word_len > KEYWORD_BYTES) return KIND_IDENT;
      for (int i = 0; i < NUM_KEYWORDS; i++) begin
        name = keyword_name(i);
        packed_name = '0;
        for (int j = 0; j < name.len(); j++) packed_name = {packed_name[55:0], name[j]};
        if (name.len() == word_len && packed_name == word) return KIND_KEY0 + 6'(i);
      end
      return KIND_IDENT;
    endfunction

    function bit pend_mode(scan_mode_e m);
      return m >= SCAN_STAR;
    endfunction

    function logic [5:0] pend_kind(scan_mode_e m, bit doubled);
      case (m)
        SCAN_STAR: return doubled ? KIND_POW  : KIND_STAR;
        SCAN_EQ:   return doubled ? KIND_EQEQ : KIND_ASSIGN;
        SCAN_BANG: return doubled ? KIND_NEQ  : KIND_NOT;
        SCAN_GT:   return doubled ? KIND_GE   : KIND_GT;
        default:   return doubled ? KIND_LE   : KIND_LT;
      endcase
    endfunction

    // Start a new token from the idle mode
    function void idle_byte(logic [7:0] c);
      logic [5:0] op_kind;
      bit         is_single;
      if (is_space(c)) return;
      if (c == "#") begin
        mode = SCAN_COMMENT;
        return;
      end
      is_single = 1'b1;
      op_kind = KIND_LBRACE;
      case (c)
        "{": op_kind = KIND_LBRACE;
        "}": op_kind = KIND_RBRACE;
        "[": op_kind = KIND_LBRACK;
        "]": op_kind = KIND_RBRACK;
        "(": op_kind = KIND_LPAREN;
        ")": op_kind = KIND_RPAREN;
        ";": op_kind = KIND_SEMI;
        ",": op_kind = KIND_COMMA;
        ".": op_kind = KIND_DOT;
        "+": op_kind = KIND_PLUS;
        "-": op_kind = KIND_MINUS;
        "/": op_kind = KIND_SLASH;
        "%": op_kind = KIND_PCT;
        "|": op_kind = KIND_BAR;
        "&": op_kind = KIND_AMP;
        default: is_single = 1'b0;
      endcase
      if (is_single) begin
        emit(op_kind, pos, pos);
        return;
      end
      tok_begin = pos;
      case (c)
        "*": mode = SCAN_STAR;
        "=": mode = SCAN_EQ;
        "!": mode = SCAN_BANG;
        ">": mode = SCAN_GT;
        "<": mode = SCAN_LT;
        "\"": mode = SCAN_STRING;
        default: begin
          if (is_digit(c)) begin
            mode = SCAN_INT;
          end else if (is_word(c)) begin
            mode = SCAN_IDENT;
            word = 64'(c);
            word_len = 1;
          end else begin
            emit(KIND_ERR, pos, pos);
            mode = SCAN_ERROR;
          end
        end
      endcase
    endfunction

    function void byte_step(logic [7:0] c);
      logic [7:0] second;
      // Resolve a pending one- or two-character operator
      if (pend_mode(mode)) begin
        second = (mode == SCAN_STAR) ? "*" : "=";
        if (c == second) begin
          emit(pend_kind(mode, 1'b1), tok_begin, pos);
          mode = SCAN_IDLE;
        end else begin
          emit(pend_kind(mode, 1'b0), tok_begin, tok_begin);
          mode = SCAN_IDLE;
          idle_byte(c);
        end
        return;
      end
      case (mode)
        SCAN_COMMENT: begin
          if (c == "\n") mode = SCAN_IDLE;
        end
        SCAN_ERROR: begin
          // drop bytes until end of text
        end
        SCAN_INT, SCAN_FLOAT: begin
          if (!is_digit(c)) begin
            if (mode == SCAN_INT && c == ".") begin
              mode = SCAN_FLOAT;
            end else begin
              emit(mode == SCAN_INT ? KIND_INT : KIND_FLOAT, tok_begin, prev_end());
              mode = SCAN_IDLE;
              idle_byte(c);
            end
          end
        end
        SCAN_IDENT: begin
          if (is_word(c)) begin
            if (word_len < KEYWORD_BYTES) begin
              word = {word[55:0], c};
              word_len++;
            end else begin
              word_len = KEYWORD_BYTES + 1;
            end
          end else begin
            emit(word_kind(), tok_begin, prev_end());
            mode = SCAN_IDLE;
            idle_byte(c);
          end
        end
        SCAN_STRING: begin
          if (c == "\"") begin
            emit(KIND_STRING, tok_begin, pos);
            mode = SCAN_IDLE;
          end else if (c == "\n") begin
            emit(KIND_ERR, tok_begin, tok_begin);
            mode = SCAN_ERROR;
          end
        end
        default: idle_byte(c);
      endcase
    endfunction

    // Flush the pending token, then close the text
    function void end_step();
      if (pend_mode(mode)) begin
        emit(pend_kind(mode, 1'b0), tok_begin, tok_begin);
      end else begin
        case (mode)
          SCAN_INT:    emit(KIND_INT, tok_begin, prev_end());
          SCAN_FLOAT:  emit(KIND_FLOAT, tok_begin, prev_end());
          SCAN_IDENT:  emit(word_kind(), tok_begin, prev_end());
          SCAN_STRING: emit(KIND_ERR, tok_begin, tok_begin);
          default: begin
          end
        endcase
      end
      emit(KIND_EOF, pos, pos);
    endfunction

    // Predict the results of one accepted input item
    function void note_item(logic [7:0] c, logic end_m);
      res_t r;
      item_res.delete();
      if (end_m) begin
        end_step();
        clear_scan();
      end else begin
        byte_step(c);
        if (pos != POS_MAX) pos++;
      end
      if (item_res.size() > 0) begin
        r = item_res[item_res.size() - 1];
        r.last = 1'b1;
        item_res[item_res.size() - 1] = r;
      end
      token_q = {token_q, item_res};
    endfunction

    function void report(string field, int unsigned want, int unsigned got);
      errors++;
      $error("%s: expected %0d, got %0d", field, want, got);
    endfunction

    // Compare one result item with the oldest prediction
    function void check_result(logic [5:0] kind, logic [15:0] s, logic [15:0] e,
                               logic last);
      res_t want;
      if (token_q.size() == 0) begin
        errors++;
        $error("unexpected result: token_kind %0d start_pos %0d end_pos %0d", kind, s, e);
        return;
      end
      want = token_q.pop_front();
      if (kind !== want.kind) report("token_kind", want.kind, kind);
      if (s !== want.start_pos) report("start_pos", want.start_pos, s);
      if (e !== want.end_pos) report("end_pos", want.end_pos, e);
      if (last !== want.last) report("run_last", want.last, last);
    endfunction

    function int unsigned pending();
      return token_q.size();
    endfunction
  endclass

endpackage

// ===== tb/tb_character_stream_tokenizer.sv =====
// ----------------------------------------------------------------------------
// tb_character_stream_tokenizer - self-checking bench for the tokenizer
// Streams directed and random source texts through the block with bursty
// input and patterned output stalls, predicts every token item and checks
// each result field.
// ----------------------------------------------------------------------------
module tb_character_stream_tokenizer;
  import cst_pkg::*;
  import token_check_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_text_byte;
  logic        in_end_marker;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [5:0]  out_token_kind;
  logic [15:0] out_start_pos;
  logic [15:0] out_end_pos;
  logic        out_run_last;

  token_scoreboard sb;
  logic [7:0]      text_q[$];
  int unsigned     burst_left;
  int              stall_phase = 0;
  logic [15:0]     stall_pattern = '1;

  string op_spellings [25] = '{
    "{", "}", "[", "]", "(", ")", ";", ",", ".", "+", "-", "**", "*",
    "/", "%", "|", "&", "==", "=", "!=", "!", ">=", ">", "<=", "<"
  };

  character_stream_tokenizer dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_text_byte  (in_text_byte),
    .in_end_marker (in_end_marker),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_token_kind(out_token_kind),
    .out_start_pos (out_start_pos),
    .out_end_pos   (out_end_pos),
    .out_run_last  (out_run_last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Stall the result channel on a rotating pattern, reloaded whenever the phase wraps
  always @(negedge clk) begin
    if (stall_phase == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pattern = '1;
        1: stall_pattern = 16'($urandom);
        2: stall_pattern = 16'($urandom | $urandom);
        default: stall_pattern = 16'($urandom & $urandom);
      endcase
      // keep one ready slot per turn to bound the longest stall
      stall_pattern[0] = 1'b1;
    end
    out_ready <= stall_pattern[stall_phase % 16];
    stall_phase = (stall_phase + 1) % 64;
  end

  // Check each accepted result item
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_token_kind, out_start_pos, out_end_pos, out_run_last);
  end

  function automatic logic [7:0] rand_letter();
    int unsigned r;
    r = $urandom_range(0, 52);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    return "_";
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_space();
    int unsigned r;
    r = $urandom_range(0, 5);
    return (r == 0) ? " " : 8'("\t" + r - 1);
  endfunction

  // Any byte that neither closes a string nor ends a comment
  function automatic logic [7:0] rand_body_byte();
    logic [7:0] c;
    do c = 8'($urandom); while (c == "\"" || c == "\n");
    return c;
  endfunction

  // Add one byte at the tail of the text
  function automatic void append_byte(logic [7:0] c);
    text_q.insert(text_q.size(), c);
  endfunction

  function automatic void push_str(string s);
    for (int i = 0; i < s.len(); i++) append_byte(s[i]);
  endfunction

  // Append one random token; noise covers stray bytes and broken strings
  function automatic void add_token(bit allow_noise);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!allow_noise && r >= 92) r = 91;
    if (r < 25) begin
      push_str(op_spellings[$urandom_range(0, 24)]);
    end else if (r < 33) begin
      repeat ($urandom_range(1, 5)) append_byte(rand_digit());
    end else if (r < 40) begin
      repeat ($urandom_range(1, 4)) append_byte(rand_digit());
      append_byte(".");
      repeat ($urandom_range(0, 3)) append_byte(rand_digit());
    end else if (r < 55) begin
      repeat ($urandom_range(1, 12)) append_byte(rand_letter());
    end else if (r < 68) begin
      push_str(keyword_name($urandom_range(0, NUM_KEYWORDS - 1)));
      if ($urandom_range(0, 3) == 0) append_byte(rand_letter());
    end else if (r < 76 || (r >= 92 && r < 96)) begin
      append_byte("\"");
      repeat ($urandom_range(0, 6)) append_byte(rand_body_byte());
      append_byte((r < 76) ? "\"" : "\n");
    end else if (r < 82) begin
      append_byte("#");
      repeat ($urandom_range(0, 8)) append_byte(rand_body_byte());
      append_byte("\n");
    end else if (r < 92) begin
      repeat ($urandom_range(1, 3)) append_byte(rand_space());
    end else begin
      append_byte(8'($urandom));
    end
  endfunction

  function automatic void build_text(bit allow_noise, int unsigned tokens);
    for (int t = 0; t < tokens; t++) begin
      add_token(allow_noise);
      if ($urandom_range(0, 1) == 1) append_byte(rand_space());
    end
    // leave a string open at the end now and then
    if (allow_noise && $urandom_range(0, 19) == 0) begin
      append_byte("\"");
      repeat ($urandom_range(0, 4)) append_byte(rand_body_byte());
    end
  endfunction

  // Send one item in bursts with random gaps, then note it once accepted
  task automatic send_item(input logic [7:0] c, input logic end_m);
    int unsigned gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_text_byte <= c;
    in_end_marker <= end_m;
    do @(posedge clk); while (!in_ready);
    sb.note_item(c, end_m);
  endtask

  task automatic send_text(input logic [7:0] end_byte);
    foreach (text_q[i]) send_item(text_q[i], 1'b0);
    send_item(end_byte, 1'b1);
    text_q.delete();
  endtask

  initial begin
    int unsigned random_items;
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_text_byte = '0;
    in_end_marker = 1'b0;
    burst_left = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty text, stray bytes at both extremes, broken strings,
    // decimal with an operator pending at the end, keyword closed by an operator
    send_text(8'hFF);
    append_byte(8'h00);
    append_byte("a");
    send_text(8'h00);
    append_byte(8'hFF);
    send_text(8'h55);
    push_str("\"a\nb");
    send_text(8'hAA);
    push_str("\"ab");
    send_text(8'h0F);
    push_str("1.5<");
    send_text(8'hF0);
    push_str("in(");
    send_text(8'h80);

    // Random texts, mostly well formed
    random_items = 0;
    while (random_items < 860) begin
      build_text(1'b1, $urandom_range(1, 16));
      random_items += text_q.size() + 1;
      send_text(8'($urandom));
    end

    // Drain outstanding results
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("character_stream_tokenizer: match");
    end else begin
      $display("character_stream_tokenizer: mismatch");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("character_stream_tokenizer: mismatch");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/cst_pkg.sv
rtl/core/cst_keyword.sv
rtl/core/cst_scan.sv
rtl/core/cst_res_queue.sv
rtl/core/character_stream_tokenizer.sv
tb/token_check_pkg.sv
tb/tb_character_stream_tokenizer.sv
